@@ hw/rtl/hksl_pkg.sv @@
// Package for the hashed-key sorted table lookup block.
// Holds field widths, operation codes, entry and control types, and the CRC-32 byte step.
// No dependencies.
package hksl_pkg;

  // table depth default and fixed field widths
  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned SHARD_W  = 8;
  localparam int unsigned CERT_W   = 32;
  localparam int unsigned EXPIRY_W = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 13;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_BYTE   = 2'd2;

  // reflected CRC-32 constants
  localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [HASH_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [HASH_W-1:0]   key;
    logic [SHARD_W-1:0]  shard;
    logic [CERT_W-1:0]   cert;
    logic [EXPIRY_W-1:0] expiry;
  } entry_t;

  // top to search unit
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] hash;
  } srch_ctl_t;

  // search unit status
  typedef struct packed {
    logic busy;
    logic done;
  } srch_sts_t;

  // search unit result, data zero when not found
  typedef struct packed {
    logic              found;
    logic [HASH_W-1:0] hash;
    entry_t            entry;
  } srch_res_t;

  // fold one byte into a reflected CRC-32, bit by bit
  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [HASH_W-1:0] c;
    c = crc ^ {{(HASH_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/hksl_ifs.sv @@
// Channel interfaces for the hashed-key sorted table lookup block.
// Request, result and configuration channels with valid/ready; depends on hksl_pkg.

interface hksl_req_if;
  import hksl_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SLOT_W-1:0]   slot;
  logic [HASH_W-1:0]   key_hash;
  logic [SHARD_W-1:0]  shard_number;
  logic [CERT_W-1:0]   certificate_number;
  logic [EXPIRY_W-1:0] expiry_time;
  logic [BYTE_W-1:0]   domain_byte;
  logic                last_byte;

  modport source (output valid, operation, slot, key_hash, shard_number,
                  certificate_number, expiry_time, domain_byte, last_byte,
                  input ready);
  modport sink (input valid, operation, slot, key_hash, shard_number,
                certificate_number, expiry_time, domain_byte, last_byte,
                output ready);
endinterface

interface hksl_rsp_if;
  import hksl_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [HASH_W-1:0]   looked_up_hash;
  logic [SHARD_W-1:0]  found_shard;
  logic [CERT_W-1:0]   found_certificate;
  logic [EXPIRY_W-1:0] found_expiry;

  modport source (output valid, found, looked_up_hash, found_shard,
                  found_certificate, found_expiry, input ready);
  modport sink (input valid, found, looked_up_hash, found_shard,
                found_certificate, found_expiry, output ready);
endinterface

interface hksl_cfg_if;
  import hksl_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] table_count;

  modport source (output valid, table_count, input ready);
  modport sink (input valid, table_count, output ready);
endinterface

@@ hw/rtl/hksl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hksl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/hksl_search.sv @@
// Binary search sequencer: one table probe per cycle through a shared key compare.
// Depends on hksl_pkg; drives the read port of the entry RAM.
module hksl_search
  import hksl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  srch_ctl_t                      ctl,
  input  logic [COUNT_W-1:0]             table_count,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  entry_t                         rd_data,
  output srch_sts_t                      sts,
  output srch_res_t                      res
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  // control state
  logic busy;
  logic done;
  logic found;
  // search window [lo, hi_x) and the probe in flight
  logic [NW-1:0]     lo;
  logic [NW-1:0]     hi_x;
  logic [NW-1:0]     mid;
  logic [HASH_W-1:0] hash;
  entry_t            hit;

  logic [31:0]   count_ext;
  logic [NW-1:0] n;
  logic [NW-1:0] mid0;
  logic          key_eq;
  logic          key_lt;
  logic [NW-1:0] lo_next;
  logic [NW-1:0] hi_x_next;
  logic [NW-1:0] mid_next;

  // clamp the entry count to the table depth
  always_comb begin
    count_ext = {{(32-COUNT_W){1'b0}}, table_count};
    if (count_ext > 32'(TABLE_DEPTH)) begin
      n = NW'(TABLE_DEPTH);
    end else begin
      n = NW'(count_ext);
    end
    mid0 = (n - NW'(1)) >> 1;
  end

  // shared compare and window update
  always_comb begin
    key_eq    = (rd_data.key == hash);
    key_lt    = (rd_data.key < hash);
    lo_next   = key_lt ? (mid + NW'(1)) : lo;
    hi_x_next = key_lt ? hi_x : mid;
    mid_next  = lo_next + ((hi_x_next - lo_next - NW'(1)) >> 1);
  end

  // first probe on start, then the next probe each cycle
  assign rd_addr = busy ? mid_next[AW-1:0] : mid0[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
    end else if (ctl.start) begin
      busy  <= (n != '0);
      done  <= (n == '0);
      found <= 1'b0;
    end else if (busy) begin
      if (key_eq) begin
        busy  <= 1'b0;
        done  <= 1'b1;
        found <= 1'b1;
      end else if (lo_next >= hi_x_next) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // window and result payload
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hash <= ctl.hash;
      lo   <= '0;
      hi_x <= n;
      mid  <= mid0;
      hit  <= '0;
    end else if (busy) begin
      if (key_eq) begin
        hit <= rd_data;
      end else begin
        lo   <= lo_next;
        hi_x <= hi_x_next;
        mid  <= mid_next;
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign res.found = found;
  assign res.hash  = hash;
  assign res.entry = hit;

endmodule

@@ hw/rtl/hashed_key_sorted_table_lookup_top.sv @@
// Hashed-key sorted table lookup: CRC-32 of nonzero domain bytes, binary search of a sorted table.
// Write and plain domain-byte requests do not hold the block busy. A lookup accepts the request,
// then probes the table, one entry RAM read per probe, then loads the result register; no new
// request is taken until the result is registered.
// Reset (rst, synchronous) clears table_count to 0 and the running CRC to all ones;
// table contents are undefined until written. Depends on hksl_pkg, hksl_ifs, hksl_ram, hksl_search.
module hashed_key_sorted_table_lookup_top
  import hksl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  hksl_req_if.sink  request,
  hksl_rsp_if.source result,
  hksl_cfg_if.sink  cfg
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic               state;
  logic               state_next;
  logic [COUNT_W-1:0] table_count;
  logic [HASH_W-1:0]  running_crc;
  logic [HASH_W-1:0]  running_crc_next;

  logic              accept;
  logic [HASH_W-1:0] crc_fold;
  logic [HASH_W-1:0] crc_kept;
  logic [31:0]       slot_ext;
  logic              ram_we;
  entry_t            wr_entry;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  srch_ctl_t         srch_ctl;
  srch_sts_t         srch_sts;
  srch_res_t         srch_res;
  logic              out_free;
  logic              load;

  // configuration register, always ready
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      table_count <= cfg.table_count;
    end
  end

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;

  // request decode: table write, lookup start, CRC fold
  always_comb begin
    slot_ext         = {{(32-SLOT_W){1'b0}}, request.slot};
    crc_fold         = crc_byte(running_crc, request.domain_byte);
    crc_kept         = (request.domain_byte != '0) ? crc_fold : running_crc;
    ram_we           = 1'b0;
    srch_ctl.start   = 1'b0;
    srch_ctl.hash    = request.key_hash;
    running_crc_next = running_crc;
    if (accept) begin
      unique case (request.operation)
        OP_WRITE: begin
          ram_we = (slot_ext < 32'(TABLE_DEPTH));
        end
        OP_LOOKUP: begin
          srch_ctl.start = 1'b1;
        end
        OP_BYTE: begin
          if (request.last_byte) begin
            srch_ctl.start   = 1'b1;
            srch_ctl.hash    = crc_kept ^ CRC_ONES;
            running_crc_next = CRC_ONES;
          end else begin
            running_crc_next = crc_kept;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_ONES;
    end else begin
      running_crc <= running_crc_next;
    end
  end

  // entry storage
  assign wr_entry.key    = request.key_hash;
  assign wr_entry.shard  = request.shard_number;
  assign wr_entry.cert   = request.certificate_number;
  assign wr_entry.expiry = request.expiry_time;

  hksl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_ext[AW-1:0]),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  hksl_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .ctl         (srch_ctl),
    .table_count (table_count),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .sts         (srch_sts),
    .res         (srch_res)
  );

  // sequencer: idle takes requests, busy waits for the search and a free result slot
  assign out_free = !result.valid || result.ready;
  assign load     = (state == S_BUSY) && srch_sts.done && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (srch_ctl.start) state_next = S_BUSY;
      S_BUSY: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.found             <= srch_res.found;
      result.looked_up_hash    <= srch_res.hash;
      result.found_shard       <= srch_res.entry.shard;
      result.found_certificate <= srch_res.entry.cert;
      result.found_expiry      <= srch_res.entry.expiry;
    end
  end

  // checks
  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    srch_ctl.start |=> (state == S_BUSY))
    else $error("lookup start did not enter busy");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    srch_sts.busy |-> !ram_we)
    else $error("table write during search");

  a_load_after_done: assert property (@(posedge clk) disable iff (rst)
    load |-> (srch_sts.done && !srch_sts.busy))
    else $error("result taken before search finished");

  a_valid_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_BUSY))
    else $error("result appeared without a lookup");

endmodule
